/* sv/dsf_pkg.sv */
// ----------------------------------------------------------------------------
// dsf_pkg
// Shared types and constants of the DLE/STX/ETX frame encoder.
// ----------------------------------------------------------------------------
package dsf_pkg;

  localparam int BYTE_W = 8;

  // configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_ESCAPE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_START  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_END    = 2'd2;

  localparam logic [BYTE_W-1:0] ESCAPE_RESET = 8'd16;
  localparam logic [BYTE_W-1:0] START_RESET  = 8'd2;
  localparam logic [BYTE_W-1:0] END_RESET    = 8'd3;

  // line byte slots of one word, in send order
  localparam int SLOTS  = 7;
  localparam int SLOT_W = 3;
  localparam logic [SLOT_W-1:0] SLOT_HEAD_ESC = 3'd0;
  localparam logic [SLOT_W-1:0] SLOT_HEAD_STX = 3'd1;
  localparam logic [SLOT_W-1:0] SLOT_STUFF    = 3'd2;
  localparam logic [SLOT_W-1:0] SLOT_DATA     = 3'd3;
  localparam logic [SLOT_W-1:0] SLOT_TAIL_ESC = 3'd4;
  localparam logic [SLOT_W-1:0] SLOT_TAIL_ETX = 3'd5;
  localparam logic [SLOT_W-1:0] SLOT_CHECK    = 3'd6;

  typedef struct packed {
    logic [BYTE_W-1:0] escape_code;
    logic [BYTE_W-1:0] start_code;
    logic [BYTE_W-1:0] end_code;
  } cfg_t;

  // classified word handed from front to back
  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic [BYTE_W-1:0] check;   // xor of frame payload so far, without end code
    logic              first;
    logic              last;
    logic              stuff;
  } cmd_t;

endpackage

/* sv/dsf_in_if.sv */
// ----------------------------------------------------------------------------
// dsf_in_if
// Payload byte channel into the frame encoder.
// ----------------------------------------------------------------------------
interface dsf_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] payload_byte;
  logic       frame_first;
  logic       frame_last;

  modport source (output valid, output payload_byte, output frame_first,
                  output frame_last, input ready);
  modport sink (input valid, input payload_byte, input frame_first,
                input frame_last, output ready);
endinterface

/* sv/dsf_out_if.sv */
// ----------------------------------------------------------------------------
// dsf_out_if
// Line byte channel out of the frame encoder.
// ----------------------------------------------------------------------------
interface dsf_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] line_byte;
  logic       run_end;
  logic       frame_done;

  modport source (output valid, output line_byte, output run_end,
                  output frame_done, input ready);
  modport sink (input valid, input line_byte, input run_end,
                input frame_done, output ready);
endinterface

/* sv/dle_stx_frame_encoder.sv */
// ----------------------------------------------------------------------------
// dle_stx_frame_encoder
// DLE/STX/ETX byte-stuffing framer with xor block check byte.
// ----------------------------------------------------------------------------
// the first line byte of a word passes the queue, then the output register
// throughput: one line byte per cycle while the receiver takes them; a word
//   causes 1 to 7 line bytes in the back end, so output bandwidth sets the pace
// the front takes a word every cycle while the QUEUE_DEPTH-entry queue has room
// reset: config returns to 16/2/3, running check to zero, queue and output empty
module dle_stx_frame_encoder #(
  parameter int QUEUE_DEPTH = 2   // power of two, at least 2
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [dsf_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [dsf_pkg::BYTE_W-1:0]    cfg_data,
  dsf_in_if.sink                        in_ch,
  dsf_out_if.source                     out_ch
);

  dsf_pkg::cfg_t cfg;
  dsf_pkg::cmd_t q_data;
  dsf_pkg::cmd_t head;
  logic          q_full;
  logic          q_push;
  logic          q_pop;
  logic          head_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.escape_code <= dsf_pkg::ESCAPE_RESET;
      cfg.start_code  <= dsf_pkg::START_RESET;
      cfg.end_code    <= dsf_pkg::END_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        dsf_pkg::REG_ESCAPE: cfg.escape_code <= cfg_data;
        dsf_pkg::REG_START:  cfg.start_code  <= cfg_data;
        dsf_pkg::REG_END:    cfg.end_code    <= cfg_data;
        default: ;
      endcase
    end
  end

  dsf_front u_front (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .in_ch  (in_ch),
    .q_full (q_full),
    .q_push (q_push),
    .q_data (q_data)
  );

  dsf_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_data  (q_data),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (head_valid),
    .head       (head)
  );

  dsf_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .head_valid (head_valid),
    .head       (head),
    .pop        (q_pop),
    .out_ch     (out_ch)
  );

endmodule

/* sv/dsf_front.sv */
// ----------------------------------------------------------------------------
// dsf_front
// Accepts payload words, tracks the running xor and classifies each word.
// ----------------------------------------------------------------------------
module dsf_front (
  input  logic          clk,
  input  logic          rst,
  input  dsf_pkg::cfg_t cfg,
  dsf_in_if.sink        in_ch,
  input  logic          q_full,
  output logic          q_push,
  output dsf_pkg::cmd_t q_data
);

  logic [dsf_pkg::BYTE_W-1:0] running_check;
  logic [dsf_pkg::BYTE_W-1:0] running_check_next;
  logic [dsf_pkg::BYTE_W-1:0] chk;

  assign in_ch.ready = !q_full;
  assign q_push      = in_ch.valid && !q_full;

  // a frame start restarts the xor
  assign chk = (in_ch.frame_first ? '0 : running_check) ^ in_ch.payload_byte;
  assign running_check_next = in_ch.frame_last ? '0 : chk;

  always_comb begin
    q_data.data  = in_ch.payload_byte;
    q_data.check = chk;
    q_data.first = in_ch.frame_first;
    q_data.last  = in_ch.frame_last;
    q_data.stuff = (in_ch.payload_byte == cfg.escape_code);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running_check <= '0;
    end else if (q_push) begin
      running_check <= running_check_next;
    end
  end

endmodule

/* sv/dsf_queue.sv */
// ----------------------------------------------------------------------------
// dsf_queue
// Small word queue between the front and the back of the encoder.
// ----------------------------------------------------------------------------
module dsf_queue #(
  parameter int DEPTH = 2
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  dsf_pkg::cmd_t push_data,
  output logic          full,
  input  logic          pop,
  output logic          head_valid,
  output dsf_pkg::cmd_t head
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  dsf_pkg::cmd_t    mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full       = (count == CNT_W'(DEPTH));
  assign head_valid = (count != '0);
  assign head       = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

/* sv/dsf_back.sv */
// ----------------------------------------------------------------------------
// dsf_back
// Expands each queued word into its line bytes, one per cycle unless stalled.
// ----------------------------------------------------------------------------
module dsf_back (
  input  logic          clk,
  input  logic          rst,
  input  dsf_pkg::cfg_t cfg,
  input  logic          head_valid,
  input  dsf_pkg::cmd_t head,
  output logic          pop,
  dsf_out_if.source     out_ch
);

  logic [dsf_pkg::SLOTS-1:0]  sent;
  logic [dsf_pkg::SLOTS-1:0]  present;
  logic [dsf_pkg::SLOTS-1:0]  remaining;
  logic [dsf_pkg::SLOTS-1:0]  sel_mask;
  logic [dsf_pkg::SLOT_W-1:0] sel;
  logic                       is_end;
  logic                       emit;
  logic [dsf_pkg::BYTE_W-1:0] byte_sel;

  logic                       out_valid;
  logic [dsf_pkg::BYTE_W-1:0] out_byte;
  logic                       out_run_end;
  logic                       out_done;

  always_comb begin
    present = '0;
    present[dsf_pkg::SLOT_HEAD_ESC] = head.first;
    present[dsf_pkg::SLOT_HEAD_STX] = head.first;
    present[dsf_pkg::SLOT_STUFF]    = head.stuff;
    present[dsf_pkg::SLOT_DATA]     = 1'b1;
    present[dsf_pkg::SLOT_TAIL_ESC] = head.last;
    present[dsf_pkg::SLOT_TAIL_ETX] = head.last;
    present[dsf_pkg::SLOT_CHECK]    = head.last;
  end

  assign remaining = present & ~sent;

  // lowest slot still to send
  always_comb begin
    sel = dsf_pkg::SLOT_DATA;
    for (int i = dsf_pkg::SLOTS - 1; i >= 0; i--) begin
      if (remaining[i]) begin
        sel = dsf_pkg::SLOT_W'(i);
      end
    end
  end

  assign sel_mask = dsf_pkg::SLOTS'(1) << sel;
  assign is_end   = ((remaining & ~sel_mask) == '0);
  assign emit     = head_valid && (!out_valid || out_ch.ready);
  assign pop      = emit && is_end;

  always_comb begin
    case (sel)
      dsf_pkg::SLOT_HEAD_ESC: byte_sel = cfg.escape_code;
      dsf_pkg::SLOT_HEAD_STX: byte_sel = cfg.start_code;
      dsf_pkg::SLOT_STUFF:    byte_sel = cfg.escape_code;
      dsf_pkg::SLOT_DATA:     byte_sel = head.data;
      dsf_pkg::SLOT_TAIL_ESC: byte_sel = cfg.escape_code;
      dsf_pkg::SLOT_TAIL_ETX: byte_sel = cfg.end_code;
      dsf_pkg::SLOT_CHECK:    byte_sel = head.check ^ cfg.end_code;
      default:                byte_sel = head.data;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sent      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (emit) begin
        sent      <= is_end ? '0 : (sent | sel_mask);
        out_valid <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_byte    <= byte_sel;
      out_run_end <= is_end;
      out_done    <= (sel == dsf_pkg::SLOT_CHECK);
    end
  end

  assign out_ch.valid      = out_valid;
  assign out_ch.line_byte  = out_byte;
  assign out_ch.run_end    = out_run_end;
  assign out_ch.frame_done = out_done;

endmodule

/* sv/dsf_checker.sv */
// ----------------------------------------------------------------------------
// dsf_checker
// Port-level checks of the frame encoder, bound to the top level.
// ----------------------------------------------------------------------------
module dsf_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic       in_last,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_byte,
  input logic       out_run_end,
  input logic       out_done
);

  // a stalled word holds
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_byte) &&
      $stable(out_run_end) && $stable(out_done))
    else $error("stalled output word changed");

  // the check byte is always the last byte of its word
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_done |-> out_run_end)
    else $error("check byte not marked as run end");

  // nothing comes out right after reset
  assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("output valid right after reset");

  // a word without a closing flag cannot produce a check byte on the next cycle
  // when the output was idle and nothing was queued before it
  assert property (@(posedge clk) disable iff (rst)
    !out_valid && in_ready && in_valid && !in_last && $past(!out_valid && !rst)
      && $past(in_ready && !in_valid)
      |=> !(out_valid && out_done))
    else $error("check byte without a closing word");

endmodule

bind dle_stx_frame_encoder dsf_checker u_dsf_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (in_ch.valid),
  .in_ready    (in_ch.ready),
  .in_last     (in_ch.frame_last),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .out_byte    (out_ch.line_byte),
  .out_run_end (out_ch.run_end),
  .out_done    (out_ch.frame_done)
);

/* sim/testbench.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Frame encoder check: payload words go in over the input channel, and every
// line word that comes out is compared with a typed row or a local encoder
// model that keeps its own running xor and code registers. A short table of
// directed words comes first, then random frames under several code settings,
// with random idling on both channels and one long receiver hold-off.
// ----------------------------------------------------------------------------
module testbench;

  localparam logic [dsf_pkg::CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
  localparam int HOLD_AT     = 140;   // words taken before the long hold-off
  localparam int HOLD_CYCLES = 120;
  localparam int QUIET_LO    = 200;   // no idling on either side in this range
  localparam int QUIET_HI    = 260;
  localparam int IDLE_PCT    = 8;
  localparam int PHASE_WORDS = 75;
  localparam int DRAIN_LIMIT = 5000;
  localparam int TAIL_CYCLES = 20;
  localparam int RUN_LIMIT_NS = 1000000;

  typedef struct packed {
    logic [dsf_pkg::BYTE_W-1:0] line_byte;
    logic                       run_end;
    logic                       frame_done;
  } line_word_t;

  // one row of the directed table: a register write or a payload word
  typedef struct packed {
    logic                          is_cfg;
    logic [dsf_pkg::CFG_IDX_W-1:0] idx;
    logic [dsf_pkg::BYTE_W-1:0]    val;
    logic                          first;
    logic                          last;
    logic [2:0]                    typed_n;   // 0: take the line words from the model
    logic [6:0][7:0]               typed;     // typed[typed_n-1] is sent first
  } step_t;

  logic                          clk;
  logic                          rst;
  logic                          cfg_we;
  logic [dsf_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [dsf_pkg::BYTE_W-1:0]    cfg_data;

  dsf_in_if  in_ch ();
  dsf_out_if out_ch ();

  dle_stx_frame_encoder DUT (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  // encoder model state
  logic [dsf_pkg::BYTE_W-1:0] esc_code = dsf_pkg::ESCAPE_RESET;
  logic [dsf_pkg::BYTE_W-1:0] stx_code = dsf_pkg::START_RESET;
  logic [dsf_pkg::BYTE_W-1:0] etx_code = dsf_pkg::END_RESET;
  logic [dsf_pkg::BYTE_W-1:0] frame_check = '0;

  line_word_t run_words [0:6];
  int         run_len;
  line_word_t expected_line_q [$];
  step_t      directed_steps [$];

  int words_taken    = 0;
  int lines_checked  = 0;
  int frames_closed  = 0;
  int reg_writes     = 0;
  int mismatch_count = 0;
  int hold_left      = 0;
  bit hold_done      = 0;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    if (mismatch_count < 30)
      $display("mismatch at %0t: %s, got %0h, want %0h", $time, what, got, want);
    mismatch_count++;
  endtask

  function automatic int idle_chance();
    if (words_taken >= QUIET_LO && words_taken < QUIET_HI) return 0;
    return IDLE_PCT;
  endfunction

  function automatic void add_line(input logic [dsf_pkg::BYTE_W-1:0] b, input logic done);
    run_words[run_len] = {b, 1'b0, done};
    run_len++;
  endfunction

  // line words caused by one payload word, running xor kept per frame
  function automatic void encode_payload(input logic [dsf_pkg::BYTE_W-1:0] b,
                                         input logic first, input logic last);
    run_len = 0;
    if (first) begin
      frame_check = '0;
      add_line(esc_code, 1'b0);
      add_line(stx_code, 1'b0);
    end
    if (b == esc_code) add_line(esc_code, 1'b0);
    add_line(b, 1'b0);
    frame_check = frame_check ^ b;
    if (last) begin
      add_line(esc_code, 1'b0);
      add_line(etx_code, 1'b0);
      add_line(frame_check ^ etx_code, 1'b1);
      frame_check = '0;
    end
    run_words[run_len-1].run_end = 1'b1;
  endfunction

  function automatic void apply_register(input logic [dsf_pkg::CFG_IDX_W-1:0] idx,
                                         input logic [dsf_pkg::BYTE_W-1:0] val);
    case (idx)
      dsf_pkg::REG_ESCAPE: esc_code = val;
      dsf_pkg::REG_START:  stx_code = val;
      dsf_pkg::REG_END:    etx_code = val;
      default: ;
    endcase
  endfunction

  function automatic logic [dsf_pkg::BYTE_W-1:0] pick_payload();
    if ($urandom_range(99) < 20) return esc_code;
    return dsf_pkg::BYTE_W'($urandom_range(255));
  endfunction

  function automatic step_t word_row(input logic [7:0] b, input logic first, input logic last,
                                     input logic [2:0] n, input logic [6:0][7:0] typed);
    step_t s;
    s = '0;
    s.val = b;
    s.first = first;
    s.last = last;
    s.typed_n = n;
    s.typed = typed;
    return s;
  endfunction

  function automatic step_t cfg_row(input logic [dsf_pkg::CFG_IDX_W-1:0] idx,
                                    input logic [7:0] val);
    step_t s;
    s = '0;
    s.is_cfg = 1'b1;
    s.idx = idx;
    s.val = val;
    return s;
  endfunction

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic drive_word(input logic [dsf_pkg::BYTE_W-1:0] b, input logic first,
                            input logic last, input logic [2:0] typed_n,
                            input logic [6:0][7:0] typed);
    while ($urandom_range(99) < idle_chance()) begin
      in_ch.valid = 1'b0;
      @(negedge clk);
    end
    in_ch.valid = 1'b1;
    in_ch.payload_byte = b;
    in_ch.frame_first = first;
    in_ch.frame_last = last;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    encode_payload(b, first, last);
    if (typed_n == 0) begin
      for (int i = 0; i < run_len; i++) expected_line_q.push_back(run_words[i]);
    end else begin
      for (int i = 0; i < typed_n; i++)
        expected_line_q.push_back({typed[typed_n-1-i], i == typed_n - 1,
                                   last && (i == typed_n - 1)});
    end
    words_taken++;
    @(negedge clk);
  endtask

  // register writes only once the encoder has nothing left to send
  task automatic write_register(input logic [dsf_pkg::CFG_IDX_W-1:0] idx,
                                input logic [dsf_pkg::BYTE_W-1:0] val);
    in_ch.valid = 1'b0;
    while (expected_line_q.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    @(negedge clk);
    cfg_we = 1'b0;
    apply_register(idx, val);
    reg_writes++;
  endtask

  task automatic random_phase(input logic [7:0] esc, input logic [7:0] stx,
                              input logic [7:0] etx);
    int start_count;
    int len;
    write_register(dsf_pkg::REG_ESCAPE, esc);
    write_register(dsf_pkg::REG_START, stx);
    write_register(dsf_pkg::REG_END, etx);
    start_count = words_taken;
    while (words_taken - start_count < PHASE_WORDS) begin
      if ($urandom_range(99) < 15) begin
        // stray word: any mix of markers
        drive_word(pick_payload(), 1'($urandom_range(1)), 1'($urandom_range(1)), 3'd0, '0);
      end else begin
        len = ($urandom_range(9) == 0) ? $urandom_range(12, 20) : $urandom_range(1, 6);
        for (int k = 0; k < len; k++)
          drive_word(pick_payload(), k == 0, k == len - 1, 3'd0, '0);
      end
    end
  endtask

  // receiver: random stalls, one long hold-off while the sender keeps offering
  initial begin
    out_ch.ready = 1'b0;
    while (rst !== 1'b0) @(negedge clk);
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        out_ch.ready = 1'b0;
        hold_left--;
      end else if (!hold_done && words_taken >= HOLD_AT) begin
        hold_done = 1;
        hold_left = HOLD_CYCLES - 1;
        out_ch.ready = 1'b0;
      end else begin
        out_ch.ready = ($urandom_range(99) >= idle_chance());
      end
    end
  end

  always @(posedge clk) begin : line_monitor
    line_word_t want;
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (expected_line_q.size() == 0) begin
        report_mismatch("line word with nothing expected", int'(out_ch.line_byte), 0);
      end else begin
        want = expected_line_q.pop_front();
        lines_checked++;
        if (out_ch.line_byte !== want.line_byte)
          report_mismatch("line_byte", int'(out_ch.line_byte), int'(want.line_byte));
        if (out_ch.run_end !== want.run_end)
          report_mismatch("run_end", int'(out_ch.run_end), int'(want.run_end));
        if (out_ch.frame_done !== want.frame_done)
          report_mismatch("frame_done", int'(out_ch.frame_done), int'(want.frame_done));
        if (want.frame_done) frames_closed++;
      end
    end
  end

  initial begin
    #(RUN_LIMIT_NS);
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    int drain;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_ch.valid = 1'b0;
    in_ch.payload_byte = '0;
    in_ch.frame_first = 1'b0;
    in_ch.frame_last = 1'b0;

    // reset codes: escape 10, start 02, end 03
    directed_steps.push_back(word_row(8'h41, 1'b1, 1'b1, 3'd6,
                                      56'({8'h10, 8'h02, 8'h41, 8'h10, 8'h03, 8'h42})));
    directed_steps.push_back(word_row(8'h10, 1'b1, 1'b1, 3'd7,
                                      {8'h10, 8'h02, 8'h10, 8'h10, 8'h10, 8'h03, 8'h13}));
    directed_steps.push_back(word_row(8'h00, 1'b1, 1'b0, 3'd3,
                                      56'({8'h10, 8'h02, 8'h00})));
    directed_steps.push_back(word_row(8'hFF, 1'b0, 1'b0, 3'd1, 56'({8'hFF})));
    directed_steps.push_back(word_row(8'h10, 1'b0, 1'b0, 3'd2, 56'({8'h10, 8'h10})));
    directed_steps.push_back(word_row(8'h80, 1'b0, 1'b1, 3'd4,
                                      56'({8'h80, 8'h10, 8'h03, 8'h6C})));
    // words with no open frame carry no header
    directed_steps.push_back(word_row(8'h55, 1'b0, 1'b0, 3'd1, 56'({8'h55})));
    directed_steps.push_back(word_row(8'hAA, 1'b0, 1'b1, 3'd4,
                                      56'({8'hAA, 8'h10, 8'h03, 8'hFC})));
    // restart inside an open frame drops the old check
    directed_steps.push_back(word_row(8'h20, 1'b1, 1'b0, 3'd3,
                                      56'({8'h10, 8'h02, 8'h20})));
    directed_steps.push_back(word_row(8'h33, 1'b1, 1'b0, 3'd3,
                                      56'({8'h10, 8'h02, 8'h33})));
    directed_steps.push_back(word_row(8'h01, 1'b0, 1'b1, 3'd4,
                                      56'({8'h01, 8'h10, 8'h03, 8'h31})));
    // escape equal to start code, unused index ignored
    directed_steps.push_back(cfg_row(dsf_pkg::REG_ESCAPE, 8'hFF));
    directed_steps.push_back(cfg_row(dsf_pkg::REG_START, 8'hFF));
    directed_steps.push_back(cfg_row(dsf_pkg::REG_END, 8'h00));
    directed_steps.push_back(cfg_row(REG_UNUSED, 8'h5A));
    directed_steps.push_back(word_row(8'hFF, 1'b1, 1'b1, 3'd0, '0));
    directed_steps.push_back(word_row(8'h00, 1'b1, 1'b0, 3'd0, '0));
    directed_steps.push_back(word_row(8'hFF, 1'b0, 1'b0, 3'd0, '0));
    directed_steps.push_back(word_row(8'hFE, 1'b0, 1'b1, 3'd0, '0));
    // escape equal to start code at zero, end code at the top
    directed_steps.push_back(cfg_row(dsf_pkg::REG_ESCAPE, 8'h00));
    directed_steps.push_back(cfg_row(dsf_pkg::REG_START, 8'h00));
    directed_steps.push_back(cfg_row(dsf_pkg::REG_END, 8'hFF));
    directed_steps.push_back(word_row(8'h00, 1'b1, 1'b1, 3'd0, '0));
    directed_steps.push_back(word_row(8'hFF, 1'b1, 1'b0, 3'd0, '0));
    directed_steps.push_back(word_row(8'h00, 1'b0, 1'b1, 3'd0, '0));
    directed_steps.push_back(word_row(8'h7F, 1'b1, 1'b1, 3'd0, '0));

    repeat (5) @(negedge clk);
    rst = 1'b0;

    foreach (directed_steps[i]) begin
      if (directed_steps[i].is_cfg)
        write_register(directed_steps[i].idx, directed_steps[i].val);
      else
        drive_word(directed_steps[i].val, directed_steps[i].first, directed_steps[i].last,
                   directed_steps[i].typed_n, directed_steps[i].typed);
    end

    random_phase(dsf_pkg::ESCAPE_RESET, dsf_pkg::START_RESET, dsf_pkg::END_RESET);
    random_phase(8'($urandom_range(255)), 8'($urandom_range(255)), 8'($urandom_range(255)));
    begin
      logic [7:0] same_code;
      same_code = 8'($urandom_range(255));
      random_phase(same_code, same_code, same_code);
    end
    begin
      logic [7:0] esc_end;
      esc_end = 8'($urandom_range(255));
      random_phase(esc_end, 8'($urandom_range(255)), esc_end);
    end
    in_ch.valid = 1'b0;

    drain = 0;
    while (expected_line_q.size() != 0 && drain < DRAIN_LIMIT) begin
      @(negedge clk);
      drain++;
    end
    if (expected_line_q.size() != 0)
      report_mismatch("line words never sent", 0, expected_line_q.size());
    repeat (TAIL_CYCLES) @(negedge clk);

    $display("run covered %0d payload words and %0d line words, %0d frames closed",
             words_taken, lines_checked, frames_closed);
    $display("code registers written %0d times, long receiver hold-off %0s",
             reg_writes, hold_done ? "done" : "missed");
    if (mismatch_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

/* files.f */
sv/dsf_pkg.sv
sv/dsf_in_if.sv
sv/dsf_out_if.sv
sv/dsf_front.sv
sv/dsf_queue.sv
sv/dsf_back.sv
sv/dle_stx_frame_encoder.sv
sv/dsf_checker.sv
sim/testbench.sv
